// ----- rtl/shns_pkg.sv -----
// Package for the SHA-256 nonce search: constants, round constants and helper functions.
package shns_pkg;

    localparam int NONCE_BITS   = 31;
    localparam int DIGEST_BYTES = 32;
    localparam int DIFF_W       = 7;
    localparam int MAX_DIGITS   = 2 * DIGEST_BYTES;
    localparam int N_ROUNDS     = 64;
    localparam int N_SCHED      = 16;
    localparam int RND_W        = $clog2(N_ROUNDS);

    localparam logic [31:0] HEADER_BITS = 32'd416;
    localparam logic [31:0] PAD_WORD    = 32'h8000_0000;
    localparam logic [255:0] INIT_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [1:0] {
        t_idle  = 2'd0,
        t_round = 2'd1,
        t_check = 2'd2
    } t_state;

    // Control from the sequencer to the cell chain.
    typedef struct packed {
        logic             load;
        logic             step;
        logic [RND_W-1:0] rnd;
    } t_cell_ctrl;

    function automatic logic [31:0] round_k(input logic [RND_W-1:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- rtl/shns_sched_cell.sv -----
// One cell of the message schedule chain: a 32-bit word passed to its neighbour each round.
module shns_sched_cell
    import shns_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_ctrl         i_ctrl,
    input  logic [31:0]        i_load_word,
    input  logic [31:0]        i_shift_word,
    output logic [31:0]        o_word
);
    logic [31:0] r_word;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_word <= i_load_word;
        end else if (i_ctrl.step) begin
            r_word <= i_shift_word;
        end
    end

    assign o_word = r_word;
endmodule

// ----- rtl/shns_round_core.sv -----
// Compression rounds: a chain of sixteen schedule cells feeding the working-variable registers.
module shns_round_core
    import shns_pkg::*;
(
    input  logic         i_clk,
    input  t_cell_ctrl   i_ctrl,
    input  logic [511:0] i_block,
    output logic [255:0] o_digest
);
    logic [31:0] w_cell [N_SCHED];
    logic [31:0] w_next;
    logic [31:0] w_s0, w_s1;
    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [31:0] n_t1, n_t2, n_bs0, n_bs1, n_ch, n_maj;

    // Cell 0 holds W[t]; the new word enters at the far end of the chain.
    assign w_s0 = rotr(w_cell[1], 7) ^ rotr(w_cell[1], 18) ^ (w_cell[1] >> 3);
    assign w_s1 = rotr(w_cell[14], 17) ^ rotr(w_cell[14], 19) ^ (w_cell[14] >> 10);
    assign w_next = w_s1 + w_cell[9] + w_s0 + w_cell[0];

    for (genvar g = 0; g < N_SCHED; g++) begin : g_cell
        shns_sched_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (i_ctrl),
            .i_load_word  (i_block[511 - 32*g -: 32]),
            .i_shift_word ((g == N_SCHED - 1) ? w_next : w_cell[(g + 1) % N_SCHED]),
            .o_word       (w_cell[g])
        );
    end

    always_comb begin
        n_bs1 = rotr(r_e, 6) ^ rotr(r_e, 11) ^ rotr(r_e, 25);
        n_ch  = (r_e & r_f) ^ (~r_e & r_g);
        n_t1  = r_h + n_bs1 + n_ch + round_k(i_ctrl.rnd) + w_cell[0];
        n_bs0 = rotr(r_a, 2) ^ rotr(r_a, 13) ^ rotr(r_a, 22);
        n_maj = (r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c);
        n_t2  = n_bs0 + n_maj;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            {r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h} <= INIT_H;
        end else if (i_ctrl.step) begin
            r_h <= r_g; r_g <= r_f; r_f <= r_e;
            r_e <= r_d + n_t1;
            r_d <= r_c; r_c <= r_b; r_b <= r_a;
            r_a <= n_t1 + n_t2;
        end
    end

    assign o_digest = {r_a + INIT_H[255:224], r_b + INIT_H[223:192],
                       r_c + INIT_H[191:160], r_d + INIT_H[159:128],
                       r_e + INIT_H[127:96],  r_f + INIT_H[95:64],
                       r_g + INIT_H[63:32],   r_h + INIT_H[31:0]};
endmodule

// ----- rtl/sha256_nonce_search.sv -----
// Top level of the SHA-256 nonce search: job sequencer, difficulty check and result register.
// Each trial nonce is one load, 64 rounds through the schedule cell chain and one check.
// The result strobe follows the last check of a job.
// Throughput is one job at a time; busy stays high up to and including the result strobe.
// The receiver cannot stall: o_done is high for one cycle only.
// Reset (synchronous, active low) returns to idle with difficulty 2.
module sha256_nonce_search
    import shns_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [DIFF_W-1:0]     i_cfg_data,
    input  logic [63:0]           i_timestamp,
    input  logic [63:0]           i_data_word,
    input  logic [63:0]           i_prev_hash_0,
    input  logic [63:0]           i_prev_hash_1,
    input  logic [63:0]           i_prev_hash_2,
    input  logic [63:0]           i_prev_hash_3,
    output logic                  o_done,
    output logic                  o_found,
    output logic [NONCE_BITS-1:0] o_winning_nonce,
    output logic [63:0]           o_hash_word_0,
    output logic [63:0]           o_hash_word_1,
    output logic [63:0]           o_hash_word_2,
    output logic [63:0]           o_hash_word_3
);
    t_state                r_state, n_state;
    logic [DIFF_W-1:0]     r_diff;
    logic [NONCE_BITS-1:0] r_nonce;
    logic [RND_W-1:0]      r_rnd;
    logic                  r_load;
    logic [383:0]          r_hdr;
    logic [511:0]          w_block;
    logic [255:0]          w_digest;
    logic [255:0]          w_mask;
    logic                  w_hit, w_last;
    logic                  r_done, r_found;
    logic [NONCE_BITS-1:0] r_win;
    logic [255:0]          r_hash;
    t_cell_ctrl            w_ctrl;
    logic                  w_accept;
    logic [31:0]           w_nonce32;

    assign w_accept  = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign w_nonce32 = 32'(r_nonce);
    assign w_block   = {r_hdr, swap32(w_nonce32), PAD_WORD, 32'h0, HEADER_BITS};

    // Leading-zero test: mask the top 4*difficulty bits, saturating at the full digest.
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            w_mask[255 - 4*i -: 4] = (7'(i) < r_diff) ? 4'hf : 4'h0;
        end
    end
    assign w_hit  = ((w_digest & w_mask) == '0);
    assign w_last = (r_nonce == '1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_idle:  if (w_accept) n_state = t_round;
            t_round: if (!r_load && r_rnd == RND_W'(N_ROUNDS - 1)) n_state = t_check;
            t_check: n_state = (w_hit || w_last) ? t_idle : t_round;
            default: n_state = t_idle;
        endcase
    end

    always_comb begin
        w_ctrl.load = r_load;
        w_ctrl.step = (r_state == t_round) && !r_load;
        w_ctrl.rnd  = r_rnd;
        busy        = (r_state != t_idle) || r_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_idle;
            r_diff  <= DIFF_W'(2);
            r_load  <= 1'b0;
            r_done  <= 1'b0;
            r_rnd   <= '0;
            r_nonce <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            if (i_cfg_valid) r_diff <= i_cfg_data;
            if (w_accept) begin
                r_nonce <= '0;
                r_load  <= 1'b1;
                r_rnd   <= '0;
            end else if (r_state == t_round) begin
                r_load <= 1'b0;
                if (!r_load) r_rnd <= r_rnd + 1'b1;
            end else if (r_state == t_check) begin
                if (w_hit || w_last) begin
                    r_done <= 1'b1;
                end else begin
                    r_nonce <= r_nonce + 1'b1;
                    r_load  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hdr <= {swap32(i_timestamp[31:0]), swap32(i_timestamp[63:32]),
                      swap32(i_data_word[31:0]), swap32(i_data_word[63:32]),
                      i_prev_hash_0, i_prev_hash_1, i_prev_hash_2, i_prev_hash_3};
        end
        if (r_state == t_check) begin
            r_found <= w_hit;
            r_win   <= r_nonce;
            r_hash  <= w_digest;
        end
    end

    shns_round_core u_core (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_block  (w_block),
        .o_digest (w_digest)
    );

    assign o_done          = r_done;
    assign o_found         = r_found;
    assign o_winning_nonce = r_win;
    assign o_hash_word_0   = r_hash[255:192];
    assign o_hash_word_1   = r_hash[191:128];
    assign o_hash_word_2   = r_hash[127:64];
    assign o_hash_word_3   = r_hash[63:0];
endmodule
